/* rtl/core/rrqs_pkg.sv */
// shared types and constants for the round-robin quantum scheduler
// used by rrqs_cell and round_robin_quantum_scheduler_top; depends on nothing

package rrqs_pkg;

	localparam int RRQS_SLOTS = 16;

	localparam int IN_W   = 24;
	localparam int OUT_W  = 48;
	localparam int BURST_W = 16;
	localparam int WAIT_W  = 32;
	localparam int QUANT_W = 8;

	localparam logic [QUANT_W-1:0] QUANTUM_RESET = 8'd4;
	localparam logic [WAIT_W-1:0]  WAIT_MAX      = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		SLOT_EMPTY = 2'd0,
		SLOT_RUN   = 2'd1,
		SLOT_WAIT  = 2'd2,
		SLOT_DONE  = 2'd3
	} slot_st_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_SCAN = 2'd1,
		ST_RUN  = 2'd2
	} sched_state_t;

	// broadcast commands from the sequencer to every cell
	typedef struct packed {
		logic place;     // write the arriving job into the fill slot
		logic tok_load;  // seed the scan token at the rotate pointer
		logic tok_shift; // pass the token one cell on
		logic take;      // token cell starts running
		logic step;      // one tick of service
		logic qhit;      // run count reaches the quantum on this tick
	} cell_ctrl_t;

	// per-cell status, already gated so the top can or-reduce it
	typedef struct packed {
		logic              fill_free;
		logic              tok_hit;
		logic              running;
		logic              last_tick;
		logic [WAIT_W-1:0] fin_wait;
	} cell_stat_t;

endpackage

/* rtl/core/rrqs_cell.sv */
// one job slot of the scheduler: burst left, status, wait counter, scan token
// depends on rrqs_pkg

module rrqs_cell #(
	parameter int IDXW  = 4,
	parameter int INDEX = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  rrqs_pkg::cell_ctrl_t           ctrl,
	input  logic [rrqs_pkg::BURST_W-1:0]   burst,
	input  logic [IDXW-1:0]                fill_ptr,
	input  logic [IDXW-1:0]                cur_ptr,
	input  logic                           token_in,
	output logic                           token_out,
	output rrqs_pkg::cell_stat_t           stat
);
	import rrqs_pkg::*;

	localparam logic [IDXW-1:0] MY_IDX = INDEX[IDXW-1:0];

	slot_st_t           status_q;
	logic [BURST_W-1:0] rem_q;
	logic [WAIT_W-1:0]  wait_q;
	logic               token_q;

	logic is_fill;
	logic is_cur;
	logic last;

	assign is_fill = (fill_ptr == MY_IDX);
	assign is_cur  = (cur_ptr == MY_IDX);
	assign last    = (rem_q == 16'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= SLOT_EMPTY;
			rem_q    <= '0;
			wait_q   <= '0;
			token_q  <= 1'b0;
		end else begin
			if (ctrl.place && is_fill) begin
				rem_q    <= burst;
				status_q <= SLOT_WAIT;
				wait_q   <= '0;
			end
			if (ctrl.take && token_q) begin
				status_q <= SLOT_RUN;
			end
			if (ctrl.step) begin
				if (is_cur) begin
					rem_q <= rem_q - 16'd1;
					if (last) begin
						status_q <= SLOT_DONE;
					end else if (ctrl.qhit) begin
						status_q <= SLOT_WAIT;
					end
				end else if (status_q == SLOT_WAIT && wait_q != WAIT_MAX) begin
					wait_q <= wait_q + 32'd1;
				end
			end
			if (ctrl.tok_load) begin
				token_q <= is_cur;
			end else if (ctrl.tok_shift) begin
				token_q <= token_in;
			end
		end
	end

	assign token_out = token_q;

	always_comb begin
		stat.fill_free = is_fill && (status_q == SLOT_EMPTY || status_q == SLOT_DONE);
		stat.tok_hit   = token_q && (status_q == SLOT_WAIT);
		stat.running   = (status_q == SLOT_RUN);
		stat.last_tick = is_cur && (status_q == SLOT_RUN) && last;
		stat.fin_wait  = stat.last_tick ? wait_q : '0;
	end

endmodule

/* rtl/core/round_robin_quantum_scheduler_top.sv */
// top level of the round-robin quantum scheduler: sequencer, pointers, output register
// depends on rrqs_pkg and rrqs_cell (one instance per job slot)

// usage
//  each input word on s_axis_* is one time tick: tdata[0] arrive, tdata[16:1] burst.
//  each tick gives exactly one output word on m_axis_*: tdata[0] ran,
//  [4:1] ran_slot, [5] finished, [37:6] finished_wait, [41:38] accepted_slot,
//  [42] rejected, upper bits zero.
//  cfg_we/cfg_wdata write the quantum (reset 4); write only while the block is idle.
//  the slots form a ring of cells; a one-hot scan token walks the ring one cell per
//  cycle from the rotate pointer to find the next waiting job.
//  steps: accept, then run the tick when a job is already running; when none is
//  running, the token scan walks the cell ring from the rotate pointer first, up to
//  one full lap, and ends on the first waiting job. one tick is worked on at a time.
//  the result sits in an output register; the next tick is accepted while it waits.
//  if the receiver stalls, the run cycle of the following tick holds until the
//  register is free, and s_axis_tready stays low until then.
//  reset empties every slot, zeroes pointers and counters, sets the quantum to 4.

module round_robin_quantum_scheduler_top #(
	parameter int SLOTS = rrqs_pkg::RRQS_SLOTS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// config
	input  logic                         cfg_we,
	input  logic [rrqs_pkg::QUANT_W-1:0] cfg_wdata,  // quantum
	// tick words in
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [rrqs_pkg::IN_W-1:0]    s_axis_tdata,  // arrive, burst
	// result words out
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [rrqs_pkg::OUT_W-1:0]   m_axis_tdata   // ran, ran_slot, finished,
	                                                    // finished_wait, accepted_slot,
	                                                    // rejected
);
	import rrqs_pkg::*;

	localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam logic [IDXW-1:0] LAST_IDX = IDXW'(SLOTS - 1);

	function automatic logic [IDXW-1:0] next_slot(input logic [IDXW-1:0] p);
		return (p == LAST_IDX) ? '0 : p + 1'b1;
	endfunction

	// slot index to the 4-bit output field, zero-extended or truncated
	function automatic logic [3:0] slot_field(input logic [IDXW-1:0] p);
		logic [IDXW+3:0] ext;
		ext = {4'b0000, p};
		return ext[3:0];
	endfunction

	// input fields
	logic               in_arrive;
	logic [BURST_W-1:0] in_burst;
	assign in_arrive = s_axis_tdata[0];
	assign in_burst  = s_axis_tdata[16:1];

	// state
	sched_state_t       state_q, state_nxt;
	logic [QUANT_W-1:0] quantum_q;
	logic [IDXW-1:0]    fill_q;
	logic [IDXW-1:0]    rot_q;
	logic [IDXW-1:0]    scan_ptr_q;
	logic [IDXW-1:0]    scan_cnt_q;
	logic [QUANT_W-1:0] run_cnt_q;
	logic               busy_q;
	logic               pend_rej_q;
	logic [3:0]         pend_acc_q;
	logic               m_tvalid_q;
	logic [OUT_W-1:0]   m_tdata_q;

	// cell ring
	cell_ctrl_t      ctrl;
	cell_stat_t      stat [SLOTS];
	logic [SLOTS-1:0] tok;
	logic [SLOTS-1:0] fill_free_v, tok_hit_v, running_v, last_v;
	logic [WAIT_W-1:0] fin_wait;

	genvar gi;
	generate
		for (gi = 0; gi < SLOTS; gi++) begin : g_cell
			rrqs_cell #(
				.IDXW (IDXW),
				.INDEX(gi)
			) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.burst    (in_burst),
				.fill_ptr (fill_q),
				.cur_ptr  (rot_q),
				.token_in (tok[(gi + SLOTS - 1) % SLOTS]),
				.token_out(tok[gi]),
				.stat     (stat[gi])
			);
			assign fill_free_v[gi] = stat[gi].fill_free;
			assign tok_hit_v[gi]   = stat[gi].tok_hit;
			assign running_v[gi]   = stat[gi].running;
			assign last_v[gi]      = stat[gi].last_tick;
		end
	endgenerate

	// only the current cell drives a nonzero wait, so an or-reduce acts as the mux
	always_comb begin
		fin_wait = '0;
		for (int i = 0; i < SLOTS; i++) begin
			fin_wait = fin_wait | stat[i].fin_wait;
		end
	end

	logic in_acc;
	logic arr_ok;
	logic found;
	logic out_free;
	logic run_go;
	logic finished;
	logic qhit;
	logic [QUANT_W-1:0] run_cnt_inc;

	assign in_acc      = s_axis_tvalid && s_axis_tready;
	assign arr_ok      = in_arrive && (in_burst != '0) && (|fill_free_v);
	assign found       = |tok_hit_v;
	assign out_free    = !m_tvalid_q || m_axis_tready;
	assign run_go      = (state_q == ST_RUN) && out_free;
	assign finished    = busy_q && (|last_v);
	assign run_cnt_inc = run_cnt_q + 8'd1;
	assign qhit        = (run_cnt_inc == quantum_q);

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_nxt = busy_q ? ST_RUN : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (found || scan_cnt_q == LAST_IDX) begin
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_axis_tready  = 1'b0;
		ctrl           = '0;
		ctrl.qhit      = qhit;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				ctrl.place    = in_acc && arr_ok;
				ctrl.tok_load = in_acc && !busy_q;
			end
			ST_SCAN: begin
				ctrl.take      = found;
				ctrl.tok_shift = !found;
			end
			ST_RUN: begin
				ctrl.step = out_free && busy_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			quantum_q  <= QUANTUM_RESET;
			fill_q     <= '0;
			rot_q      <= '0;
			scan_ptr_q <= '0;
			scan_cnt_q <= '0;
			run_cnt_q  <= '0;
			busy_q     <= 1'b0;
			pend_rej_q <= 1'b0;
			pend_acc_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) begin
				quantum_q <= cfg_wdata;
			end
			// arrival is handled in the accept cycle, ahead of the scan
			if (in_acc) begin
				pend_rej_q <= in_arrive && !arr_ok;
				pend_acc_q <= arr_ok ? slot_field(fill_q) : 4'd0;
				if (arr_ok) begin
					fill_q <= next_slot(fill_q);
				end
				scan_ptr_q <= rot_q;
				scan_cnt_q <= '0;
			end
			// token walk: claim the first waiting slot it meets
			if (state_q == ST_SCAN) begin
				if (found) begin
					rot_q     <= scan_ptr_q;
					run_cnt_q <= '0;
					busy_q    <= 1'b1;
				end else begin
					scan_ptr_q <= next_slot(scan_ptr_q);
					scan_cnt_q <= scan_cnt_q + 1'b1;
				end
			end
			// one tick of service, result into the output register
			if (run_go && busy_q) begin
				run_cnt_q <= run_cnt_inc;
				if (finished) begin
					busy_q <= 1'b0;
				end else if (qhit) begin
					busy_q <= 1'b0;
					rot_q  <= next_slot(rot_q);
				end
			end
			if (run_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (run_go) begin
			m_tdata_q <= {5'b00000,
			              pend_rej_q,
			              pend_acc_q,
			              fin_wait,
			              finished,
			              busy_q ? slot_field(rot_q) : 4'd0,
			              busy_q};
		end
	end

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = m_tdata_q;

	// at most one cell can hold the token on a waiting slot
	a_tok_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_hit_v))
		else $error("scan token hit more than one slot");

	// a running job exists exactly when the scheduler is busy
	a_busy_run: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> $onehot(running_v))
		else $error("busy without exactly one running slot");

	a_idle_norun: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (running_v == '0))
		else $error("running slot while not busy");

	// a scan only starts when no job holds the processor
	a_scan_notbusy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !busy_q)
		else $error("scan while a job is running");

endmodule
